### src/ppt_pkg.sv
// Shared types and constants of the periodic priority task picker.
package ppt_pkg;

  localparam int FUNC_W = 2;
  localparam int PRIO_W = 8;
  localparam int RATE_W = 16;
  localparam int TIME_W = 32;
  localparam int DONE_W = 4;
  localparam int ST_W   = 3;
  localparam int TID_W  = 4;
  // slot index inside the chain, wide enough for the largest table
  localparam int ID_W   = 6;

  localparam int PER_W  = 10;
  localparam int DIV_W  = 10;
  localparam logic [DIV_W-1:0] DIV_NUM = 10'd1000;

  localparam int IN_W   = 64;
  localparam int OUT_W  = 8;

  localparam logic [FUNC_W-1:0] FN_CREATE   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_PICK     = 2'd1;
  localparam logic [FUNC_W-1:0] FN_COMPLETE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_IDLE    = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd2;
  localparam logic [ST_W-1:0] ST_ZERO    = 3'd3;
  localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd4;

  // broadcast write into one slot cell
  typedef struct packed {
    logic              create;
    logic              complete;
    logic [ID_W-1:0]   addr;
    logic [PRIO_W-1:0] prio;
    logic [PER_W-1:0]  period;
    logic [TIME_W-1:0] stamp;
  } slot_wr_t;

  // best-so-far candidate handed down the chain
  typedef struct packed {
    logic              found;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } cand_t;

endpackage

### src/ppt_div.sv
// Serial restoring divider: DIV_NUM / divisor, one quotient bit per cycle.
module ppt_div
  import ppt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RATE_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  quot_o
);

  localparam int CNT_W = $clog2(DIV_W);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [RATE_W-1:0] div_q;
  logic [RATE_W-1:0] rem_q;
  logic [RATE_W-1:0] rem_d;
  logic [DIV_W-1:0]  num_q;
  logic [DIV_W-1:0]  quot_q;
  logic [RATE_W:0]   trial;
  logic              fits;

  always_comb begin
    trial = {rem_q, num_q[DIV_W-1]};
    fits  = trial >= {1'b0, div_q};
    rem_d = fits ? RATE_W'(trial - {1'b0, div_q}) : trial[RATE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q  <= divisor_i;
      rem_q  <= '0;
      num_q  <= DIV_NUM;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      num_q  <= {num_q[DIV_W-2:0], 1'b0};
      quot_q <= {quot_q[DIV_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### src/ppt_cell.sv
// One task slot: holds its state and refines the candidate passed from its neighbor.
module ppt_cell
  import ppt_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slot_wr_t          wr_i,
  input  logic              active_i,
  input  logic [TIME_W-1:0] now_i,
  input  cand_t             cand_i,
  output cand_t             cand_o
);

  localparam logic [ID_W-1:0] MY_ID = ID_W'(IDX);

  logic [PRIO_W-1:0] prio_q;
  logic [PER_W-1:0]  period_q;
  logic [TIME_W-1:0] last_q;
  logic              has_run_q;
  cand_t             cand_q;
  cand_t             cand_d;
  logic [TIME_W-1:0] dt;
  logic              due;
  logic              sel;

  always_comb begin
    dt     = now_i - last_q;
    due    = active_i && (!has_run_q || dt > TIME_W'(period_q));
    // >= so the later slot wins a tie
    sel    = due && (!cand_i.found || prio_q >= cand_i.prio);
    cand_d = sel ? '{found: 1'b1, prio: prio_q, id: MY_ID} : cand_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_run_q <= 1'b0;
      cand_q    <= '0;
    end else begin
      cand_q <= cand_d;
      if (wr_i.addr == MY_ID) begin
        if (wr_i.create) begin
          has_run_q <= 1'b0;
        end else if (wr_i.complete) begin
          has_run_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.addr == MY_ID) begin
      if (wr_i.create) begin
        prio_q   <= wr_i.prio;
        period_q <= wr_i.period;
        last_q   <= wr_i.stamp;
      end else if (wr_i.complete) begin
        last_q <= wr_i.stamp;
      end
    end
  end

  assign cand_o = cand_q;

endmodule

### src/periodic_priority_task_picker.sv
// Fixed-priority periodic task picker: a row of slot cells with a serial period divider.
//
// Input stream s_axis: one word per request. func selects create, pick or
// complete. Output stream m_axis: one status/task_id word per create, pick or
// complete; func 3 is taken and dropped without a result.
// Path from accept to the result being loaded into the output register:
//   complete:           straight to the output stage
//   create, rejected:   straight to the output stage
//   create, accepted:   after the 10-step serial divide of 1000 by the rate
//   pick:               after the candidate walks the cell row,
//                       one cell per cycle, so the pick time grows with MAX_TASKS
// One request is in flight at a time; s_axis_tready_o rises again once the
// result sits in the output register, so a new word is taken while the last
// result still waits. If the receiver stalls, the finished result holds in the
// output register and the next result waits inside until it is taken.
// Reset clears the task count and the has-run flags; the table is then empty
// and usable as soon as reset is released.
module periodic_priority_task_picker
  import ppt_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // func[1:0], task_priority[9:2], rate_hz[25:10], time_ms[57:26],
  // done_task[61:58], zero[63:62]
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // status[2:0], task_id[6:3], zero[7]
  output logic [OUT_W-1:0] m_axis_tdata_o
);

  localparam int CW   = $clog2(MAX_TASKS + 1);
  localparam int CMPW = (CW > DONE_W) ? CW : DONE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_EMIT
  } state_e;

  state_e            state_q;
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     scan_q;
  logic [TIME_W-1:0] now_q;
  logic [PRIO_W-1:0] prio_q;
  logic [ST_W-1:0]   res_st_q;
  logic [TID_W-1:0]  res_id_q;
  logic              m_valid_q;
  logic [OUT_W-1:0]  m_data_q;

  logic [FUNC_W-1:0] in_func;
  logic [PRIO_W-1:0] in_prio;
  logic [RATE_W-1:0] in_rate;
  logic [TIME_W-1:0] in_time;
  logic [DONE_W-1:0] in_done;

  logic              accept;
  logic              emit_go;
  logic              done_bad;
  logic              div_start;
  logic              div_done;
  logic [DIV_W-1:0]  div_quot;
  slot_wr_t          wr;
  cand_t             chain [MAX_TASKS+1];
  logic [MAX_TASKS-1:0] active;
  cand_t             best;

  assign in_func = s_axis_tdata_i[1:0];
  assign in_prio = s_axis_tdata_i[9:2];
  assign in_rate = s_axis_tdata_i[25:10];
  assign in_time = s_axis_tdata_i[57:26];
  assign in_done = s_axis_tdata_i[61:58];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  // output register is free or drains this cycle
  assign emit_go         = (state_q == S_EMIT) && (!m_valid_q || m_axis_tready_i);
  assign done_bad        = CMPW'(in_done) >= CMPW'(count_q);
  assign div_start       = accept && in_func == FN_CREATE && in_rate != '0
                           && count_q != CW'(MAX_TASKS);

  always_comb begin
    wr          = '0;
    wr.create   = (state_q == S_DIV) && div_done;
    wr.complete = accept && in_func == FN_COMPLETE && !done_bad;
    wr.addr     = wr.create ? ID_W'(count_q) : ID_W'(in_done);
    wr.prio     = prio_q;
    wr.period   = div_quot;
    wr.stamp    = wr.create ? '0 : in_time;
  end

  ppt_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (in_rate),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign chain[0] = '0;

  for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
    assign active[k] = CW'(k) < count_q;

    ppt_cell #(
      .IDX (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_i     (wr),
      .active_i (active[k]),
      .now_i    (now_q),
      .cand_i   (chain[k]),
      .cand_o   (chain[k+1])
    );
  end

  assign best = chain[MAX_TASKS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      scan_q    <= '0;
      now_q     <= '0;
      prio_q    <= '0;
      res_st_q  <= ST_OK;
      res_id_q  <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (emit_go) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (in_func)
              FN_CREATE: begin
                res_id_q <= '0;
                if (in_rate == '0) begin
                  res_st_q <= ST_ZERO;
                  state_q  <= S_EMIT;
                end else if (count_q == CW'(MAX_TASKS)) begin
                  res_st_q <= ST_FULL;
                  state_q  <= S_EMIT;
                end else begin
                  prio_q  <= in_prio;
                  state_q <= S_DIV;
                end
              end
              FN_PICK: begin
                now_q   <= in_time;
                scan_q  <= '0;
                state_q <= S_SCAN;
              end
              FN_COMPLETE: begin
                res_st_q <= done_bad ? ST_UNKNOWN : ST_OK;
                res_id_q <= done_bad ? '0 : in_done;
                state_q  <= S_EMIT;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_st_q <= ST_OK;
            res_id_q <= TID_W'(count_q);
            count_q  <= count_q + 1'b1;
            state_q  <= S_EMIT;
          end
        end
        S_SCAN: begin
          // last cell output settles in the cycle after it sees the final input
          scan_q <= scan_q + 1'b1;
          if (scan_q == CW'(MAX_TASKS)) begin
            res_st_q <= best.found ? ST_OK : ST_IDLE;
            res_id_q <= best.found ? TID_W'(best.id) : '0;
            state_q  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            m_data_q <= {1'b0, res_id_q, res_st_q};
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_TASKS))
    else $error("task count above table size");

  a_create_bumps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.create |=> count_q == $past(count_q) + 1'b1)
    else $error("create did not advance task count");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> m_data_q[ST_W-1:0] <= ST_UNKNOWN)
    else $error("undefined status code on output");

  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> div_quot <= DIV_NUM)
    else $error("period above 1000 ms");

endmodule

### test/periodic_priority_task_picker_tb.sv
// Self-checking bench for the periodic priority task picker: stream driver, monitor, table model.
module periodic_priority_task_picker_tb
  import ppt_pkg::*;
();

  localparam int N_SLOTS     = 16;
  localparam int N_RANDOM    = 1750;
  localparam int STUCK_LIMIT = 3000;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AFTER  = 600;
  localparam logic [FUNC_W-1:0] FN_NONE = 2'd3;

  // first field in the lowest bits, as on s_axis_tdata
  typedef struct packed {
    logic [DONE_W-1:0] done;
    logic [TIME_W-1:0] now;
    logic [RATE_W-1:0] rate;
    logic [PRIO_W-1:0] prio;
    logic [FUNC_W-1:0] func;
  } req_t;

  typedef struct packed {
    logic [TID_W-1:0] tid;
    logic [ST_W-1:0]  status;
  } reply_t;

  logic             clk_i    = 1'b0;
  logic             rst_ni   = 1'b0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  periodic_priority_task_picker #(
    .MAX_TASKS(N_SLOTS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // mirror of the task table
  int unsigned       tasks_made = 0;
  logic [PRIO_W-1:0] tbl_prio   [N_SLOTS];
  logic [PER_W-1:0]  tbl_period [N_SLOTS];
  logic [TIME_W-1:0] tbl_finish [N_SLOTS];
  bit                tbl_ran    [N_SLOTS];

  req_t   request_q [$];
  reply_t reply_q   [$];

  req_t cur_req     = '0;
  bit   req_busy    = 1'b0;
  int   tx_idle     = 0;
  bit   tx_burst    = 1'b0;
  int   rx_idle     = 0;
  bit   rx_burst    = 1'b0;
  int   hold_left   = 0;
  bit   hold_done   = 1'b0;
  bit   in_fire     = 1'b0;
  bit   out_fire    = 1'b0;
  int   words_total = 0;
  int   words_taken = 0;
  int   stuck_cycles = 0;
  int   err_cnt     = 0;
  int   n_checked   = 0;
  int   gen_made    = 0;
  int   n_status [8];

  // Applies one request word to the table mirror and gives the reply it owes.
  task automatic table_step(input req_t rq, output bit has_reply, output reply_t rp);
    bit                found;
    int                best;
    logic [TIME_W-1:0] age;
    found     = 1'b0;
    best      = 0;
    has_reply = 1'b1;
    rp        = '0;
    case (rq.func)
      FN_CREATE: begin
        if (rq.rate == '0) begin
          rp.status = ST_ZERO;
        end else if (tasks_made >= N_SLOTS) begin
          rp.status = ST_FULL;
        end else begin
          tbl_prio[tasks_made]   = rq.prio;
          tbl_period[tasks_made] = PER_W'(DIV_NUM / rq.rate);
          tbl_finish[tasks_made] = '0;
          tbl_ran[tasks_made]    = 1'b0;
          rp.status = ST_OK;
          rp.tid    = TID_W'(tasks_made);
          tasks_made++;
        end
      end
      FN_PICK: begin
        for (int s = 0; s < int'(tasks_made); s++) begin
          age = rq.now - tbl_finish[s];
          // due if never run or strictly past its period; newer slot wins ties
          if (!tbl_ran[s] || age > TIME_W'(tbl_period[s])) begin
            if (!found || tbl_prio[s] >= tbl_prio[best]) begin
              best  = s;
              found = 1'b1;
            end
          end
        end
        rp.status = found ? ST_OK : ST_IDLE;
        rp.tid    = found ? TID_W'(best) : '0;
      end
      FN_COMPLETE: begin
        if (rq.done >= tasks_made) begin
          rp.status = ST_UNKNOWN;
        end else begin
          tbl_finish[rq.done] = rq.now;
          tbl_ran[rq.done]    = 1'b1;
          rp.status = ST_OK;
          rp.tid    = rq.done;
        end
      end
      default: has_reply = 1'b0;
    endcase
  endtask

  task automatic push_req(input logic [FUNC_W-1:0] func, input logic [PRIO_W-1:0] prio,
                          input logic [RATE_W-1:0] rate, input logic [TIME_W-1:0] now,
                          input logic [DONE_W-1:0] done);
    req_t rq;
    rq.func = func;
    rq.prio = prio;
    rq.rate = rate;
    rq.now  = now;
    rq.done = done;
    request_q.push_back(rq);
    words_total++;
    if (func == FN_CREATE && rate != '0) gen_made++;
  endtask

  // sender: one word at a time, random gap after each accepted word
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) begin
        req_busy = 1'b0;
        if ($urandom_range(0, 99) == 0) tx_burst = !tx_burst;
        tx_idle = tx_burst ? 0 : $urandom_range(0, 6);
      end
      if (!req_busy) begin
        if (tx_idle > 0) begin
          tx_idle--;
        end else if (request_q.size() != 0) begin
          cur_req  = request_q.pop_front();
          req_busy = 1'b1;
        end
      end
      s_tvalid <= req_busy;
      s_tdata  <= {{(IN_W - $bits(req_t)){1'b0}}, cur_req};
    end
  end

  // receiver: random gap after each taken word, plus the long hold
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) begin
        if ($urandom_range(0, 99) == 0) rx_burst = !rx_burst;
        rx_idle = rx_burst ? 0 : $urandom_range(0, 6);
      end
      if (rx_idle > 0) begin
        rx_idle--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (hold_left == 0);
      end
    end
  end

  // one long receiver hold-off so the block backs up into its input
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && words_taken >= HOLD_AFTER) begin
        hold_left <= LONG_HOLD;
        hold_done <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    reply_t got;
    reply_t want;
    reply_t rp;
    bit     has_reply;
    if (!rst_ni) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= s_tvalid && s_tready;
      out_fire <= m_tvalid && m_tready;
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(reply_t)-1:0];
        if (reply_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected word, expected none, got status %0d task %0d",
                   $time, got.status, got.tid);
        end else begin
          want = reply_q.pop_front();
          n_checked++;
          n_status[want.status]++;
          if (got.status !== want.status) begin
            err_cnt++;
            $display("%0t: status mismatch, expected %0d got %0d",
                     $time, want.status, got.status);
          end
          if (got.tid !== want.tid) begin
            err_cnt++;
            $display("%0t: task_id mismatch, expected %0d got %0d",
                     $time, want.tid, got.tid);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        table_step(cur_req, has_reply, rp);
        if (has_reply) reply_q.push_back(rp);
        words_taken <= words_taken + 1;
      end
      stuck_cycles <= ((s_tvalid && s_tready) || (m_tvalid && m_tready)) ? 0
                                                                          : stuck_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stuck_cycles < STUCK_LIMIT) @(negedge clk_i);
    $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    req_t              rq;
    logic [TIME_W-1:0] clock_ms;
    int                roll;
    int                create_pct;
    int                live;
    int                n_real;

    // empty table
    push_req(FN_PICK, 8'h00, 16'h0000, 32'h0000_0000, 4'h0);
    push_req(FN_COMPLETE, 8'h00, 16'h0000, 32'h0000_0000, 4'h0);
    push_req(FN_CREATE, 8'hFF, 16'h0000, 32'h0000_0000, 4'h0);
    push_req(FN_NONE, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 4'hF);
    // slowest rate, fastest rate, a tie on top priority
    push_req(FN_CREATE, 8'hFF, 16'd1, 32'h0000_0000, 4'h0);
    push_req(FN_CREATE, 8'h00, 16'hFFFF, 32'h0000_0000, 4'h0);
    push_req(FN_CREATE, 8'hFF, 16'd1000, 32'h0000_0000, 4'h0);
    push_req(FN_PICK, 8'h00, 16'h0000, 32'd0, 4'h0);
    push_req(FN_COMPLETE, 8'h00, 16'h0000, 32'd100, 4'd2);
    push_req(FN_PICK, 8'h00, 16'h0000, 32'd100, 4'h0);
    push_req(FN_COMPLETE, 8'h00, 16'h0000, 32'd100, 4'd0);
    push_req(FN_COMPLETE, 8'h00, 16'h0000, 32'd100, 4'd1);
    // nothing due, then the zero-period task, then period boundary
    push_req(FN_PICK, 8'h00, 16'h0000, 32'd100, 4'h0);
    push_req(FN_PICK, 8'h00, 16'h0000, 32'd101, 4'h0);
    push_req(FN_PICK, 8'h00, 16'h0000, 32'd102, 4'h0);
    push_req(FN_COMPLETE, 8'h00, 16'h0000, 32'd200, 4'hF);
    push_req(FN_COMPLETE, 8'h00, 16'h0000, 32'd200, 4'd3);
    push_req(FN_PICK, 8'h00, 16'h0000, 32'hFFFF_FFFF, 4'h0);
    push_req(FN_CREATE, 8'h80, 16'd1001, 32'h0000_0000, 4'h0);
    push_req(FN_CREATE, 8'h80, 16'd999, 32'h0000_0000, 4'h0);
    // finish just before wrap, pick just after it
    push_req(FN_COMPLETE, 8'h00, 16'h0000, 32'hFFFF_FFF0, 4'd4);
    push_req(FN_PICK, 8'h00, 16'h0000, 32'h0000_0000, 4'h0);
    push_req(FN_PICK, 8'h00, 16'h0000, 32'hFFFF_FFF1, 4'h0);

    clock_ms = 32'hFFFF_FC00;
    n_real   = 0;
    while (n_real < N_RANDOM) begin
      rq.func = FN_PICK;
      rq.prio = PRIO_W'($urandom());
      rq.rate = RATE_W'($urandom());
      rq.now  = $urandom();
      rq.done = DONE_W'($urandom());
      roll       = $urandom_range(0, 99);
      create_pct = (gen_made < N_SLOTS) ? 35 : 8;
      live       = (gen_made < N_SLOTS) ? gen_made : N_SLOTS;
      if (roll < create_pct) begin
        rq.func = FN_CREATE;
        if ($urandom_range(0, 1)) rq.prio = $urandom_range(0, 1) ? 8'h40 : 8'h80;
        case ($urandom_range(0, 4))
          0:       rq.rate = '0;
          1:       rq.rate = RATE_W'($urandom_range(1, 50));
          2:       rq.rate = RATE_W'($urandom_range(1, 1000));
          3:       rq.rate = RATE_W'($urandom_range(1001, 65535));
          default: ;
        endcase
      end else if (roll < create_pct + 4) begin
        rq.func = FN_NONE;
      end else if (roll < create_pct + 48) begin
        clock_ms = clock_ms + $urandom_range(0, 300);
        if ($urandom_range(0, 49) == 0) clock_ms = $urandom();
        rq.now = clock_ms;
      end else begin
        rq.func = FN_COMPLETE;
        if (live > 0 && $urandom_range(0, 3) != 0) rq.done = DONE_W'($urandom_range(0, live - 1));
        if ($urandom_range(0, 19) != 0) rq.now = clock_ms - $urandom_range(0, 20);
      end
      push_req(rq.func, rq.prio, rq.rate, rq.now, rq.done);
      if (rq.func != FN_NONE) n_real++;
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (words_taken < words_total || reply_q.size() != 0) @(negedge clk_i);
    repeat (N_SLOTS + 8) @(posedge clk_i);

    $display("Sent %0d words (creates, picks, completions, undefined codes); %0d replies checked",
             words_total, n_checked);
    $display("Replies: %0d ok, %0d idle, %0d table full, %0d zero rate, %0d unknown task",
             n_status[ST_OK], n_status[ST_IDLE], n_status[ST_FULL], n_status[ST_ZERO],
             n_status[ST_UNKNOWN]);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
